// ===== sv/ccnmr_pkg.sv =====
// Shared types, constants and helpers for the camera capture block.
package ccnmr_pkg;

    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 21;
    localparam int PIXEL_W     = 16;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd240;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_SYNC  = 2'd1,
        FUNC_PIXEL = 2'd2
    } func_t;

    // Each lane byte holds four data bits of two samples, first sample in the low nibble.
    function automatic logic [PIXEL_W-1:0] merge_nibbles(
        input logic [BYTE_W-1:0] low_lane,
        input logic [BYTE_W-1:0] high_lane
    );
        return {high_lane[7:4], low_lane[7:4], high_lane[3:0], low_lane[3:0]};
    endfunction

endpackage

// ===== sv/ccnmr_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface ccnmr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ccnmr_pkg::CFG_INDEX_W-1:0]  index;
    logic [ccnmr_pkg::CFG_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/ccnmr_in_if.sv =====
// Input item channel: function code and the two lane bytes.
interface ccnmr_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic [ccnmr_pkg::BYTE_W-1:0]  low_lane_byte;
    logic [ccnmr_pkg::BYTE_W-1:0]  high_lane_byte;

    modport source (output valid, output func, output low_lane_byte,
                    output high_lane_byte, input ready);
    modport sink   (input valid, input func, input low_lane_byte,
                    input high_lane_byte, output ready);
endinterface

// ===== sv/ccnmr_out_if.sv =====
// Result channel: frame buffer write and capture status.
interface ccnmr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [ccnmr_pkg::ADDR_W-1:0]  write_addr;
    logic [ccnmr_pkg::PIXEL_W-1:0] write_pixel;
    logic                          show_frame;
    logic                          capture_armed;
    logic                          capture_running;
    logic                          buffer_full;

    modport source (output valid, output write_valid, output write_addr,
                    output write_pixel, output show_frame, output capture_armed,
                    output capture_running, output buffer_full, input ready);
    modport sink   (input valid, input write_valid, input write_addr,
                    input write_pixel, input show_frame, input capture_armed,
                    input capture_running, input buffer_full, output ready);
endinterface

// ===== sv/camera_capture_nibble_merge_rotate.sv =====
// Camera frame capture with nibble merge and 90 degree rotated write addresses.
//
//  Channel  Direction  Carries
//  cfg      sink       image_width / image_height register writes
//  item     sink       func, low_lane_byte, high_lane_byte
//  result   source     write_valid, write_addr, write_pixel, show_frame, flags
//
// An item is taken into an input register and its result is loaded into the result
// register when that register is empty or result.ready is high; one item per cycle is
// sustained while result.ready stays high. The single h * (w - 1 - col) multiply lies between the two registers.
// The result register holds while result.ready is low and the input register
// still takes one more item, after which item.ready falls.
// Reset clears the capture flags and counters and loads 320 x 240.
module camera_capture_nibble_merge_rotate #(
    parameter int MAX_DIM = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    ccnmr_cfg_if.sink    cfg,
    ccnmr_in_if.sink     item,
    ccnmr_out_if.source  result
);
    import ccnmr_pkg::*;

    localparam int DW = $clog2(MAX_DIM) + 1;
    localparam int PW = (2 * DW + 2 > ADDR_W) ? 2 * DW + 2 : ADDR_W;

    function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0)
            return DW'(1);
        else if (v32 > 32'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return DW'(v32);
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    // Input register
    logic              stage_valid_reg;
    func_t             stage_func_reg;
    logic [BYTE_W-1:0] stage_low_reg;
    logic [BYTE_W-1:0] stage_high_reg;

    // Capture state
    logic          armed_reg, armed_next;
    logic          running_reg, running_next;
    logic          full_reg, full_next;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;

    // Result register
    logic               res_valid_reg;
    logic               res_write_reg, res_write_next;
    logic               res_show_reg, res_show_next;
    logic [ADDR_W-1:0]  res_addr_reg;
    logic [PIXEL_W-1:0] res_pixel_reg;

    logic advance;
    logic item_take;

    logic [DW-1:0]   w_eff, h_eff, w_m1, c_lim, diff;
    logic [DW-1:0]   col_inc, row_inc;
    logic [2*DW-1:0] prod;
    logic [PW-1:0]   addr_wide;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign advance   = stage_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !stage_valid_reg || advance;
    assign item_take = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_take)
            stage_valid_reg <= 1'b1;
        else if (advance)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            stage_func_reg <= func_t'(item.func);
            stage_low_reg  <= item.low_lane_byte;
            stage_high_reg <= item.high_lane_byte;
        end
    end

    // Rotated address of the current pixel: 2*row + 2*h*(w-1-col).
    always_comb
    begin
        w_eff     = clamp_dim(width_reg);
        h_eff     = clamp_dim(height_reg);
        w_m1      = w_eff - DW'(1);
        c_lim     = (col_reg > w_m1) ? w_m1 : col_reg;
        diff      = w_m1 - c_lim;
        prod      = (2 * DW)'(h_eff) * (2 * DW)'(diff);
        addr_wide = (PW'(row_reg) << 1) + (PW'(prod) << 1);
        col_inc   = col_reg + DW'(1);
        row_inc   = row_reg + DW'(1);
    end

    always_comb
    begin
        armed_next     = armed_reg;
        running_next   = running_reg;
        full_next      = full_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        res_write_next = 1'b0;
        res_show_next  = 1'b0;
        case (stage_func_reg)
            FUNC_START:
            begin
                if (!armed_reg)
                begin
                    armed_next   = 1'b1;
                    running_next = 1'b0;
                end
            end
            FUNC_SYNC:
            begin
                if (armed_reg && !running_reg)
                begin
                    running_next = 1'b1;
                    full_next    = 1'b0;
                    col_next     = '0;
                    row_next     = '0;
                end
                else if (armed_reg && running_reg)
                begin
                    armed_next    = 1'b0;
                    running_next  = 1'b0;
                    res_show_next = 1'b1;
                end
            end
            FUNC_PIXEL:
            begin
                if (armed_reg && running_reg && !full_reg)
                begin
                    // A row past the height can only follow a height shrunk mid-frame.
                    if (row_reg >= h_eff)
                        full_next = 1'b1;
                    else
                    begin
                        res_write_next = 1'b1;
                        if (col_inc >= w_eff)
                        begin
                            col_next = '0;
                            row_next = row_inc;
                            if (row_inc >= h_eff)
                                full_next = 1'b1;
                        end
                        else
                            col_next = col_inc;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            running_reg   <= 1'b0;
            full_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                armed_reg   <= armed_next;
                running_reg <= running_next;
                full_reg    <= full_next;
                col_reg     <= col_next;
                row_reg     <= row_next;
            end
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_write_reg <= res_write_next;
            res_show_reg  <= res_show_next;
            res_addr_reg  <= res_write_next ? addr_wide[ADDR_W-1:0] : '0;
            res_pixel_reg <= res_write_next ? merge_nibbles(stage_low_reg, stage_high_reg)
                                            : '0;
        end
    end

    // The flags change only when a result is loaded, so they stay in step with it.
    assign result.valid           = res_valid_reg;
    assign result.write_valid     = res_write_reg;
    assign result.write_addr      = res_addr_reg;
    assign result.write_pixel     = res_pixel_reg;
    assign result.show_frame      = res_show_reg;
    assign result.capture_armed   = armed_reg;
    assign result.capture_running = running_reg;
    assign result.buffer_full     = full_reg;

    a_running_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> armed_reg)
        else $error("capture running without being armed");

    a_write_while_running: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_write_reg) |-> (armed_reg && running_reg))
        else $error("pixel write reported outside a running capture");

    a_show_ends_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_show_reg) |-> (!armed_reg && !running_reg && !res_write_reg))
        else $error("frame end reported while capture still active");

    a_addr_even: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_write_reg) |-> (res_addr_reg[0] == 1'b0))
        else $error("pixel write address is odd");

    a_stage_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |-> !item.ready)
        else $error("input register would be overwritten");

endmodule
